@@ sv/bpa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

  localparam int unsigned TREE_PAGES_DEF = 1024;
  localparam int unsigned RESET_MANAGED  = 1024;

  localparam int unsigned PAGE_W = 11;
  localparam int unsigned OFF_W  = 10;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } bpa_cmd_e;

  typedef enum logic [1:0] {
    STS_DONE      = 2'd0,
    STS_NO_PAGES  = 2'd1,
    STS_NO_FIT    = 2'd2,
    STS_NOT_ALLOC = 2'd3
  } bpa_status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_A_CHK,
    ST_A_DOWN,
    ST_A_MARK,
    ST_F_UP,
    ST_U_WR,
    ST_DONE
  } bpa_state_e;

endpackage

`default_nettype wire

@@ sv/bpa_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bpa_req_if;
  import bpa_pkg::*;
  logic              valid;
  logic              ready;
  bpa_cmd_e          command;
  logic [PAGE_W-1:0] page_count;
  logic [OFF_W-1:0]  block_offset;

  modport source (output valid, command, page_count, block_offset, input ready);
  modport sink   (input valid, command, page_count, block_offset, output ready);
endinterface

interface bpa_rsp_if;
  import bpa_pkg::*;
  logic              valid;
  logic              ready;
  bpa_status_e       status;
  logic [OFF_W-1:0]  result_offset;
  logic [PAGE_W-1:0] block_pages;
  logic [PAGE_W-1:0] free_left;

  modport source (output valid, status, result_offset, block_pages, free_left, input ready);
  modport sink   (input valid, status, result_offset, block_pages, free_left, output ready);
endinterface

`default_nettype wire

@@ sv/bpa_tree_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bpa_tree_mem #(
  parameter int unsigned DEPTH = 2 * bpa_pkg::TREE_PAGES_DEF - 1,
  parameter int unsigned VW    = $clog2(bpa_pkg::TREE_PAGES_DEF) + 1,
  parameter int unsigned IW    = $clog2(bpa_pkg::TREE_PAGES_DEF) + 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  logic [VW-1:0] wdata_i,
  input  logic [IW-1:0] raddr_i,
  output logic [VW-1:0] rdata_o
);

  logic [VW-1:0] mem_q [DEPTH];
  logic [VW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/bpa_node_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bpa_node_unit #(
  parameter int unsigned VW = $clog2(bpa_pkg::TREE_PAGES_DEF) + 1
) (
  input  logic [VW-1:0] a_i,
  input  logic [VW-1:0] b_i,
  input  logic [VW-1:0] up_i,
  input  logic          merge_i,
  output logic [VW-1:0] res_o
);

  logic [VW:0]   sum;
  logic [VW-1:0] larger;

  assign sum    = {1'b0, a_i} + {1'b0, b_i};
  assign larger = (a_i > b_i) ? a_i : b_i;

  // two wholly free buddies join into one block of the parent's size
  assign res_o = (merge_i && (sum == {1'b0, up_i})) ? up_i : larger;

endmodule

`default_nettype wire

@@ sv/buddy_page_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Binary buddy allocator over TREE_PAGES pages, kept as a tree of longest-free-block sizes in a
// one-read, one-write memory. One request is in work at a time. The single read port supplies
// one tree node per cycle on the way down or while a free climbs to its block, and one sibling
// per cycle on the way back up. After reset and after every write of managed_pages all
// 2*TREE_PAGES-1 tree nodes (2047 at the default) are refilled one node a cycle, during which no
// request is taken. A finished result sits in an output register, so the next request is taken
// while it waits.
module buddy_page_allocator #(
  parameter int unsigned TREE_PAGES = bpa_pkg::TREE_PAGES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bpa_pkg::PAGE_W-1:0] cfg_wdata_i,
  bpa_req_if.sink                   req_i,
  bpa_rsp_if.source                 rsp_o
);
  import bpa_pkg::*;

  localparam int unsigned LOG   = $clog2(TREE_PAGES);
  localparam int unsigned VW    = LOG + 1;
  localparam int unsigned IW    = LOG + 1;
  localparam int unsigned NODES = 2 * TREE_PAGES - 1;
  localparam int unsigned CW    = (VW > PAGE_W) ? VW : PAGE_W;

  localparam logic [VW-1:0] FULL       = VW'(TREE_PAGES);
  localparam logic [VW-1:0] RESET_FREE =
    VW'((RESET_MANAGED > TREE_PAGES) ? TREE_PAGES : RESET_MANAGED);
  localparam logic [IW-1:0] LAST  = IW'(NODES - 1);
  localparam logic [IW-1:0] LEAF0 = IW'(TREE_PAGES - 1);

  bpa_state_e  state_q, state_d;
  logic [IW-1:0] clr_idx_q, clr_idx_d;
  logic [VW-1:0] clr_sz_q, clr_sz_d;
  logic [VW-1:0] free_q, free_d;
  logic          rsp_valid_q, rsp_valid_d;
  logic          rsp_load;

  bpa_cmd_e      cmd_q, cmd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [VW-1:0] nsz_q, nsz_d;
  logic [LOG-1:0] off_q, off_d;
  logic [VW-1:0] cur_q, cur_d;
  logic [VW-1:0] blk_q, blk_d;
  bpa_status_e   sts_q, sts_d;

  bpa_status_e       rsp_sts_q;
  logic [OFF_W-1:0]  rsp_off_q;
  logic [PAGE_W-1:0] rsp_blk_q;
  logic [PAGE_W-1:0] rsp_free_q;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [VW-1:0] mem_wdata;
  logic [IW-1:0] mem_raddr;
  logic [VW-1:0] mem_rdata;
  logic [VW-1:0] unit_res;

  logic [VW-1:0] nsz_half;
  logic [VW-1:0] nsz_dbl;
  logic          go_left;
  logic [IW-1:0] idx_new;
  logic [IW-1:0] idx_new_left;
  logic [IW-1:0] parent_idx;
  logic [IW-1:0] idx_sib;
  logic [IW-1:0] par_sib;
  logic [VW-1:0] fc_sub;
  logic [VW:0]   fc_sum;
  logic [VW-1:0] fc_add;
  logic [VW-1:0] cfg_val;

  bpa_tree_mem #(
    .DEPTH (NODES),
    .VW    (VW),
    .IW    (IW)
  ) u_tree_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bpa_node_unit #(
    .VW (VW)
  ) u_node_unit (
    .a_i     (cur_q),
    .b_i     (mem_rdata),
    .up_i    (nsz_dbl),
    .merge_i (cmd_q == CMD_FREE),
    .res_o   (unit_res)
  );

  assign nsz_half     = nsz_q >> 1;
  assign nsz_dbl      = nsz_q << 1;
  assign go_left      = CW'(mem_rdata) >= cnt_q;
  assign idx_new      = (idx_q << 1) + (go_left ? IW'(1) : IW'(2));
  assign idx_new_left = (idx_new << 1) + IW'(1);
  assign parent_idx   = (idx_q - IW'(1)) >> 1;
  // left children sit at odd indexes
  assign idx_sib      = idx_q[0] ? idx_q + IW'(1) : idx_q - IW'(1);
  assign par_sib      = parent_idx[0] ? parent_idx + IW'(1) : parent_idx - IW'(1);

  assign fc_sub = (free_q > nsz_q) ? free_q - nsz_q : '0;
  assign fc_sum = {1'b0, free_q} + {1'b0, nsz_q};
  assign fc_add = (fc_sum > {1'b0, FULL}) ? FULL : fc_sum[VW-1:0];

  assign cfg_val = (cfg_wdata_i == '0) ? VW'(1) :
                   (CW'(cfg_wdata_i) > CW'(TREE_PAGES)) ? FULL : VW'(cfg_wdata_i);

  assign req_i.ready = (state_q == ST_IDLE) && !cfg_we_i;

  always_comb begin
    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    clr_sz_d    = clr_sz_q;
    free_d      = free_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_load    = 1'b0;
    cmd_d       = cmd_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    nsz_d       = nsz_q;
    off_d       = off_q;
    cur_d       = cur_q;
    blk_d       = blk_q;
    sts_d       = sts_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = '0;
    mem_raddr   = idx_q;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
        mem_wdata = clr_sz_q;
        if (clr_idx_q == LAST) begin
          state_d = ST_IDLE;
        end else begin
          clr_idx_d = clr_idx_q + IW'(1);
          // next index opens a new tree level
          if (((clr_idx_q + IW'(2)) & (clr_idx_q + IW'(1))) == '0) begin
            clr_sz_d = clr_sz_q >> 1;
          end
        end
      end
      ST_IDLE: begin
        if (req_i.valid && req_i.ready) begin
          cmd_d   = req_i.command;
          cnt_d   = (req_i.page_count == '0) ? CW'(1) : CW'(req_i.page_count);
          off_d   = '0;
          state_d = ST_START;
          if (req_i.command == CMD_FREE) begin
            idx_d = LEAF0 + IW'(LOG'(req_i.block_offset));
            nsz_d = VW'(1);
          end else begin
            idx_d = '0;
            nsz_d = FULL;
          end
        end
      end
      ST_START: begin
        mem_raddr = idx_q;
        state_d   = (cmd_q == CMD_FREE) ? ST_F_UP : ST_A_CHK;
      end
      ST_A_CHK: begin
        if (CW'(free_q) < cnt_q) begin
          sts_d   = STS_NO_PAGES;
          blk_d   = '0;
          state_d = ST_DONE;
        end else if (CW'(mem_rdata) < cnt_q) begin
          sts_d   = STS_NO_FIT;
          blk_d   = '0;
          state_d = ST_DONE;
        end else if (CW'(nsz_half) < cnt_q) begin
          state_d = ST_A_MARK;
        end else begin
          mem_raddr = (idx_q << 1) + IW'(1);
          state_d   = ST_A_DOWN;
        end
      end
      ST_A_DOWN: begin
        nsz_d = nsz_half;
        idx_d = idx_new;
        off_d = go_left ? off_q : off_q + LOG'(nsz_half);
        if (CW'(nsz_half >> 1) < cnt_q) begin
          state_d = ST_A_MARK;
        end else begin
          mem_raddr = idx_new_left;
        end
      end
      ST_A_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = '0;
        cur_d     = '0;
        blk_d     = nsz_q;
        sts_d     = STS_DONE;
        free_d    = fc_sub;
        mem_raddr = idx_sib;
        state_d   = (idx_q == '0) ? ST_DONE : ST_U_WR;
      end
      ST_F_UP: begin
        if (mem_rdata == '0) begin
          mem_we    = 1'b1;
          mem_waddr = idx_q;
          mem_wdata = nsz_q;
          cur_d     = nsz_q;
          blk_d     = nsz_q;
          sts_d     = STS_DONE;
          free_d    = fc_add;
          mem_raddr = idx_sib;
          state_d   = (idx_q == '0) ? ST_DONE : ST_U_WR;
        end else if (idx_q == '0) begin
          sts_d   = STS_NOT_ALLOC;
          blk_d   = '0;
          state_d = ST_DONE;
        end else begin
          idx_d     = parent_idx;
          nsz_d     = nsz_dbl;
          mem_raddr = parent_idx;
        end
      end
      ST_U_WR: begin
        // sibling arrives from memory, own value is carried in cur_q
        mem_we    = 1'b1;
        mem_waddr = parent_idx;
        mem_wdata = unit_res;
        cur_d     = unit_res;
        nsz_d     = nsz_dbl;
        idx_d     = parent_idx;
        mem_raddr = par_sib;
        if (parent_idx == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load    = 1'b1;
          rsp_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      free_d    = cfg_val;
      state_d   = ST_CLEAR;
      clr_idx_d = '0;
      clr_sz_d  = FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      clr_sz_q    <= FULL;
      free_q      <= RESET_FREE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      clr_sz_q    <= clr_sz_d;
      free_q      <= free_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    cnt_q <= cnt_d;
    idx_q <= idx_d;
    nsz_q <= nsz_d;
    off_q <= off_d;
    cur_q <= cur_d;
    blk_q <= blk_d;
    sts_q <= sts_d;
    if (rsp_load) begin
      rsp_sts_q  <= sts_q;
      rsp_off_q  <= (cmd_q == CMD_FREE) ? '0 : OFF_W'(off_q);
      rsp_blk_q  <= PAGE_W'(blk_q);
      rsp_free_q <= PAGE_W'(free_q);
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_sts_q;
  assign rsp_o.result_offset = rsp_off_q;
  assign rsp_o.block_pages   = rsp_blk_q;
  assign rsp_o.free_left     = rsp_free_q;

endmodule

`default_nettype wire

@@ sv/bpa_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bpa_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       req_valid_i,
  input wire logic                       req_ready_i,
  input wire logic                       rsp_valid_i,
  input wire logic                       rsp_ready_i,
  input wire logic [1:0]                 status_i,
  input wire logic [bpa_pkg::OFF_W-1:0]  result_offset_i,
  input wire logic [bpa_pkg::PAGE_W-1:0] block_pages_i
);
  import bpa_pkg::*;

  // a waiting result beat holds until taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i)
      && $stable(block_pages_i) && $stable(result_offset_i))
    else $error("result beat changed while stalled");

  // one request in work at a time
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while previous one in work");

  a_refusal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i != STS_DONE) |-> (block_pages_i == '0) && (result_offset_i == '0))
    else $error("refusal carries a block");

  a_block_pow2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == STS_DONE) |-> $onehot0(block_pages_i))
    else $error("block size not a power of two");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .status_i        (rsp_o.status),
  .result_offset_i (rsp_o.result_offset),
  .block_pages_i   (rsp_o.block_pages)
);

`default_nettype wire
